// ===== hw/rtl/file_range_stripe_mapper_macros.svh =====
// Assertion macros shared by the stripe mapper RTL.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef FILE_RANGE_STRIPE_MAPPER_MACROS_SVH
`define FILE_RANGE_STRIPE_MAPPER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FRSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FRSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frsm_pkg.sv =====
// Package for the file range stripe mapper: constants, codes and the
// structs passed between the config block, the shared unit and the sequencer.
package frsm_pkg;

  localparam int unsigned MaxChunks = 64;
  localparam int unsigned CntW      = $clog2(MaxChunks);
  localparam int unsigned StepW     = 7;

  localparam logic [StepW-1:0] DivSteps = StepW'(64);
  localparam logic [StepW-1:0] MulSteps = StepW'(32);

  localparam logic [31:0] StripeUnitRst  = 32'd4194304;
  localparam logic [15:0] StripeCountRst = 16'd1;
  localparam logic [31:0] ObjectSizeRst  = 32'd4194304;

  typedef enum logic [1:0] {
    CfgStripeUnit  = 2'd0,
    CfgStripeCount = 2'd1,
    CfgObjectSize  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    AluDiv = 1'b0,
    AluMul = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [31:0] stripe_unit;
    logic [15:0] stripe_count;
    logic [31:0] object_size;
  } cfg_t;

  typedef struct packed {
    logic        go;
    alu_op_e     op;
    logic [63:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [31:0] rem;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/file_range_stripe_mapper.sv =====
// Top level of the file range stripe mapper: sequencer and chunk walker.
// Depends on frsm_pkg, frsm_cfg, frsm_alu and file_range_stripe_mapper_macros.svh.
//
//   channel   | direction | handshake
//   ----------+-----------+-------------------------------------------
//   request   | in        | start, busy: taken when start && !busy
//   result    | out       | result_strobe_o: one cycle a result
//   config    | in        | cfg_valid_i, cfg_ready_o (ready when idle)
//
// A request runs four 64-step divides and two 32-step multiplies on the shared unit
// to set up the first chunk; the walk then alternates StEmit and StAdv, giving one
// result per StEmit with no further division.
// A zero-length request is taken and gives nothing; busy stays low.
// Reset is asynchronous, active low, and leaves the block idle with reset config.
// Results cannot be held off; the receiver takes each one in its strobe cycle.
`include "file_range_stripe_mapper_macros.svh"

module file_range_stripe_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] file_id_i,
  input  logic [63:0] revision_i,
  input  logic [62:0] start_offset_i,
  input  logic [31:0] range_length_i,
  output logic        result_strobe_o,
  output logic [63:0] owner_file_o,
  output logic [63:0] owner_revision_o,
  output logic [62:0] object_number_o,
  output logic [62:0] object_offset_o,
  output logic [31:0] chunk_length_o,
  output logic [31:0] buffer_offset_o,
  output logic        last_o,
  output logic        truncated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StDivPo  = 9'b000000010,
    StDivBlk = 9'b000000100,
    StDivRow = 9'b000001000,
    StDivSet = 9'b000010000,
    StMulSb  = 9'b000100000,
    StMulOff = 9'b001000000,
    StEmit   = 9'b010000000,
    StAdv    = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  logic                      wait_q;
  logic                      strobe_q;
  logic [frsm_pkg::CntW-1:0] chunk_cnt_q;

  frsm_pkg::cfg_t     cfg;
  frsm_pkg::alu_req_t alu_req;
  frsm_pkg::alu_rsp_t alu_rsp;

  logic [63:0] file_q;
  logic [63:0] rev_q;
  logic [62:0] work_q;
  logic [31:0] left_q;
  logic [31:0] buf_q;
  logic [31:0] per_obj_q;
  logic [31:0] within_q;
  logic [15:0] pos_q;
  logic [31:0] r_q;
  logic [62:0] setbase_q;
  logic [62:0] roff_q;

  logic [62:0] object_number_q;
  logic [62:0] object_offset_q;
  logic [31:0] chunk_length_q;
  logic [31:0] buffer_offset_q;
  logic        last_q;
  logic        truncated_q;

  logic [31:0] su_eff;
  logic [15:0] sc_eff;
  logic [31:0] room;
  logic [31:0] len;
  logic [31:0] left_nx;
  logic        cnt_full;
  logic        last_c;
  logic        computing;
  logic        accept;
  logic [16:0] pos_inc;
  logic [32:0] r_inc;

  frsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .ready_i     (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  frsm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign su_eff = (cfg.stripe_unit == '0) ? 32'd1 : cfg.stripe_unit;
  assign sc_eff = (cfg.stripe_count == '0) ? 16'd1 : cfg.stripe_count;

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;

  assign computing = (state_q == StDivPo) || (state_q == StDivBlk) || (state_q == StDivRow) ||
                     (state_q == StDivSet) || (state_q == StMulSb) || (state_q == StMulOff);

  // Operand selection for the shared unit, one launch per compute state.
  always_comb begin
    alu_req.go = computing && !wait_q;
    alu_req.op = frsm_pkg::AluDiv;
    alu_req.a  = {1'b0, work_q};
    alu_req.b  = su_eff;
    case (state_q)
      StDivPo: begin
        alu_req.a = {32'd0, cfg.object_size};
      end
      StDivRow: begin
        alu_req.b = {16'd0, sc_eff};
      end
      StDivSet: begin
        alu_req.b = per_obj_q;
      end
      StMulSb: begin
        alu_req.op = frsm_pkg::AluMul;
        alu_req.b  = {16'd0, sc_eff};
      end
      StMulOff: begin
        alu_req.op = frsm_pkg::AluMul;
        alu_req.a  = {32'd0, r_q};
      end
      default: ;
    endcase
  end

  // Chunk arithmetic for the current position.
  assign room     = su_eff - within_q;
  assign len      = (left_q < room) ? left_q : room;
  assign left_nx  = left_q - len;
  assign cnt_full = (chunk_cnt_q == frsm_pkg::CntW'(frsm_pkg::MaxChunks - 1));
  assign last_c   = (left_nx == '0) || cnt_full;
  assign pos_inc  = {1'b0, pos_q} + 17'd1;
  assign r_inc    = {1'b0, r_q} + 33'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (accept && range_length_i != '0) state_d = StDivPo;
      StDivPo:  if (alu_rsp.done) state_d = StDivBlk;
      StDivBlk: if (alu_rsp.done) state_d = StDivRow;
      StDivRow: if (alu_rsp.done) state_d = StDivSet;
      StDivSet: if (alu_rsp.done) state_d = StMulSb;
      StMulSb:  if (alu_rsp.done) state_d = StMulOff;
      StMulOff: if (alu_rsp.done) state_d = StEmit;
      StEmit:   state_d = last_c ? StIdle : StAdv;
      StAdv:    state_d = StEmit;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wait_q      <= 1'b0;
      strobe_q    <= 1'b0;
      chunk_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == StEmit);
      if (alu_req.go) begin
        wait_q <= 1'b1;
      end else if (alu_rsp.done) begin
        wait_q <= 1'b0;
      end
      if (accept) begin
        chunk_cnt_q <= '0;
      end else if (state_q == StEmit && !cnt_full) begin
        chunk_cnt_q <= chunk_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          file_q <= file_id_i;
          rev_q  <= revision_i;
          work_q <= start_offset_i;
          left_q <= range_length_i;
          buf_q  <= '0;
        end
      end
      StDivPo: begin
        if (alu_rsp.done) begin
          per_obj_q <= (alu_rsp.res[31:0] == '0) ? 32'd1 : alu_rsp.res[31:0];
        end
      end
      StDivBlk: begin
        if (alu_rsp.done) begin
          work_q   <= alu_rsp.res[62:0];
          within_q <= alu_rsp.rem;
        end
      end
      StDivRow: begin
        if (alu_rsp.done) begin
          work_q <= alu_rsp.res[62:0];
          pos_q  <= alu_rsp.rem[15:0];
        end
      end
      StDivSet: begin
        if (alu_rsp.done) begin
          work_q <= alu_rsp.res[62:0];
          r_q    <= alu_rsp.rem;
        end
      end
      StMulSb: begin
        if (alu_rsp.done) begin
          setbase_q <= alu_rsp.res[62:0];
        end
      end
      StMulOff: begin
        if (alu_rsp.done) begin
          roff_q <= alu_rsp.res[62:0];
        end
      end
      StEmit: begin
        object_number_q <= setbase_q + {47'd0, pos_q};
        object_offset_q <= roff_q + {31'd0, within_q};
        chunk_length_q  <= len;
        buffer_offset_q <= buf_q;
        last_q          <= last_c;
        truncated_q     <= cnt_full && (left_nx != '0);
        left_q          <= left_nx;
      end
      StAdv: begin
        // Every later chunk starts on a block boundary: step to the next block.
        buf_q    <= buf_q + chunk_length_q;
        within_q <= '0;
        if (pos_inc == {1'b0, sc_eff}) begin
          pos_q <= '0;
          if (r_inc == {1'b0, per_obj_q}) begin
            r_q       <= '0;
            roff_q    <= '0;
            setbase_q <= setbase_q + {47'd0, sc_eff};
          end else begin
            r_q    <= r_inc[31:0];
            roff_q <= roff_q + {31'd0, su_eff};
          end
        end else begin
          pos_q <= pos_inc[15:0];
        end
      end
      default: ;
    endcase
  end

  assign result_strobe_o  = strobe_q;
  assign owner_file_o     = file_q;
  assign owner_revision_o = rev_q;
  assign object_number_o  = object_number_q;
  assign object_offset_o  = object_offset_q;
  assign chunk_length_o   = chunk_length_q;
  assign buffer_offset_o  = buffer_offset_q;
  assign last_o           = last_q;
  assign truncated_o      = truncated_q;

  `FRSM_ASSERT_IMP(a_strobe_after_emit, result_strobe_o, $past(state_q == StEmit), "result without emit")
  `FRSM_ASSERT_IMP(a_trunc_on_last, result_strobe_o && truncated_o, last_o, "truncation flag off the last result")
  `FRSM_ASSERT_IMP(a_len_nonzero, result_strobe_o, chunk_length_o != '0, "empty chunk emitted")
  `FRSM_ASSERT_NXT(a_zero_len_idle, accept && range_length_i == '0, !busy, "zero-length request went busy")
  `FRSM_ASSERT_IMP(a_alu_done_waited, alu_rsp.done, wait_q && computing, "unit finished with nothing launched")

endmodule

// ===== hw/rtl/frsm_cfg.sv =====
// Configuration registers of the stripe mapper (stripe unit, count, object size).
// Depends on frsm_pkg.
module frsm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output frsm_pkg::cfg_t      cfg_o
);

  frsm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stripe_unit  <= frsm_pkg::StripeUnitRst;
      cfg_q.stripe_count <= frsm_pkg::StripeCountRst;
      cfg_q.object_size  <= frsm_pkg::ObjectSizeRst;
    end else if (cfg_valid_i && ready_i) begin
      case (cfg_index_i)
        frsm_pkg::CfgStripeUnit:  cfg_q.stripe_unit  <= cfg_data_i;
        frsm_pkg::CfgStripeCount: cfg_q.stripe_count <= cfg_data_i[15:0];
        frsm_pkg::CfgObjectSize:  cfg_q.object_size  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/frsm_alu.sv =====
// Shared iterative unit: restoring 64/32 divide (one quotient bit a cycle)
// and 64x32 shift-add multiply (one multiplier bit a cycle). Depends on frsm_pkg.
module frsm_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frsm_pkg::alu_req_t req_i,
  output frsm_pkg::alu_rsp_t rsp_o
);

  logic [frsm_pkg::StepW-1:0] cnt_q;
  logic                       done_q;
  frsm_pkg::alu_op_e          op_q;
  logic [63:0]                x_q;
  logic [63:0]                acc_q;
  logic [32:0]                rem_q;
  logic [31:0]                b_q;

  logic [32:0] shifted;
  logic        ge;
  logic [32:0] rem_d;

  assign shifted = {rem_q[31:0], x_q[63]};
  assign ge      = shifted >= {1'b0, b_q};
  assign rem_d   = ge ? (shifted - {1'b0, b_q}) : shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        cnt_q <= (req_i.op == frsm_pkg::AluDiv) ? frsm_pkg::DivSteps : frsm_pkg::MulSteps;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == frsm_pkg::StepW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      op_q  <= req_i.op;
      x_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (op_q == frsm_pkg::AluDiv) begin
        rem_q <= rem_d;
        x_q   <= {x_q[62:0], ge};
      end else begin
        if (b_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[62:0], 1'b0};
        b_q <= {1'b0, b_q[31:1]};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == frsm_pkg::AluDiv) ? x_q : acc_q;
  assign rsp_o.rem  = rem_q[31:0];

endmodule

// ===== test/tb_file_range_stripe_mapper.sv =====
// Testbench for file_range_stripe_mapper: directed and random byte ranges under several
// stripe layouts, each result checked against a chunk predictor held in a scoreboard class.
// Depends on frsm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_file_range_stripe_mapper;

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned EndCycles    = 400;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned PhaseItems   = 25;
  localparam logic [62:0] OffsetMax    = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] owner_file;
    logic [63:0] owner_revision;
    logic [62:0] object_number;
    logic [62:0] object_offset;
    logic [31:0] chunk_length;
    logic [31:0] buffer_offset;
    logic        last;
    logic        truncated;
  } chunk_t;

  class chunk_scoreboard;
    chunk_t      expected_chunks[$];
    logic [31:0] unit_bytes;
    logic [15:0] stripe_width;
    logic [31:0] object_bytes;
    int unsigned mismatches;

    function new();
      unit_bytes   = frsm_pkg::StripeUnitRst;
      stripe_width = frsm_pkg::StripeCountRst;
      object_bytes = frsm_pkg::ObjectSizeRst;
      mismatches   = 0;
    endfunction

    function void write_reg(frsm_pkg::cfg_idx_e idx, logic [31:0] data);
      case (idx)
        frsm_pkg::CfgStripeUnit:  unit_bytes   = data;
        frsm_pkg::CfgStripeCount: stripe_width = data[15:0];
        frsm_pkg::CfgObjectSize:  object_bytes = data;
        default: ;
      endcase
    endfunction

    // Walk the range and queue one chunk per stripe-unit piece.
    function void map_range(logic [63:0] fid, logic [63:0] rev, logic [62:0] offset,
                            logic [31:0] length);
      logic [63:0] unit, count, per_object, cur, left, block, row, pos, blk_off, piece;
      chunk_t      c;
      int unsigned n;
      unit       = (unit_bytes == 0) ? 64'd1 : 64'(unit_bytes);
      count      = (stripe_width == 0) ? 64'd1 : 64'(stripe_width);
      per_object = 64'(object_bytes) / unit;
      if (per_object == 0) per_object = 64'd1;
      cur  = 64'(offset);
      left = 64'(length);
      n    = 0;
      while (left != 0 && n < frsm_pkg::MaxChunks) begin
        block   = cur / unit;
        row     = block / count;
        pos     = block % count;
        blk_off = cur % unit;
        piece   = (left < unit - blk_off) ? left : unit - blk_off;
        c.owner_file     = fid;
        c.owner_revision = rev;
        c.object_number  = 63'((row / per_object) * count + pos);
        c.object_offset  = 63'((row % per_object) * unit + blk_off);
        c.chunk_length   = piece[31:0];
        c.buffer_offset  = 32'(cur - 64'(offset));
        left = left - piece;
        cur  = cur + piece;
        n++;
        c.last      = (left == 0) || (n == frsm_pkg::MaxChunks);
        c.truncated = (left != 0) && (n == frsm_pkg::MaxChunks);
        expected_chunks.insert(expected_chunks.size(), c);
      end
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t want;
      if (expected_chunks.size() == 0) begin
        $display("%0t: chunk expected none actual obj %h off %h len %h", $time,
                 got.object_number, got.object_offset, got.chunk_length);
        mismatches++;
        return;
      end
      want = expected_chunks.pop_front();
      check_field("owner_file", want.owner_file, got.owner_file);
      check_field("owner_revision", want.owner_revision, got.owner_revision);
      check_field("object_number", 64'(want.object_number), 64'(got.object_number));
      check_field("object_offset", 64'(want.object_offset), 64'(got.object_offset));
      check_field("chunk_length", 64'(want.chunk_length), 64'(got.chunk_length));
      check_field("buffer_offset", 64'(want.buffer_offset), 64'(got.buffer_offset));
      check_field("last", 64'(want.last), 64'(got.last));
      check_field("truncated", 64'(want.truncated), 64'(got.truncated));
    endfunction

    function int unsigned pending();
      return expected_chunks.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] file_id_i;
  logic [63:0] revision_i;
  logic [62:0] start_offset_i;
  logic [31:0] range_length_i;
  logic        result_strobe_o;
  logic [63:0] owner_file_o;
  logic [63:0] owner_revision_o;
  logic [62:0] object_number_o;
  logic [62:0] object_offset_o;
  logic [31:0] chunk_length_o;
  logic [31:0] buffer_offset_o;
  logic        last_o;
  logic        truncated_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  chunk_scoreboard sb;
  chunk_t          seen_chunk;
  int unsigned     stall_cycles = 0;
  bit              gaps_on = 1'b1;
  logic [31:0]     layout_unit;

  always #6 clk_i = ~clk_i;

  file_range_stripe_mapper i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .file_id_i        (file_id_i),
    .revision_i       (revision_i),
    .start_offset_i   (start_offset_i),
    .range_length_i   (range_length_i),
    .result_strobe_o  (result_strobe_o),
    .owner_file_o     (owner_file_o),
    .owner_revision_o (owner_revision_o),
    .object_number_o  (object_number_o),
    .object_offset_o  (object_offset_o),
    .chunk_length_o   (chunk_length_o),
    .buffer_offset_o  (buffer_offset_o),
    .last_o           (last_o),
    .truncated_o      (truncated_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Observe every transaction at the rising edge; results before new requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o) begin
        seen_chunk.owner_file     = owner_file_o;
        seen_chunk.owner_revision = owner_revision_o;
        seen_chunk.object_number  = object_number_o;
        seen_chunk.object_offset  = object_offset_o;
        seen_chunk.chunk_length   = chunk_length_o;
        seen_chunk.buffer_offset  = buffer_offset_o;
        seen_chunk.last           = last_o;
        seen_chunk.truncated      = truncated_o;
        sb.check_chunk(seen_chunk);
      end
      if (start && !busy) sb.map_range(file_id_i, revision_i, start_offset_i, range_length_i);
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(frsm_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (result_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_range(logic [63:0] fid, logic [63:0] rev, logic [62:0] offset,
                            logic [31:0] length);
    int unsigned gap;
    gap            = pick_gap();
    file_id_i      = fid;
    revision_i     = rev;
    start_offset_i = offset;
    range_length_i = length;
    start          = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold requests until every expected chunk is out and the block is idle.
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(frsm_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_layout(logic [31:0] unit, logic [31:0] width, logic [31:0] osize);
    drain();
    write_reg(frsm_pkg::CfgStripeUnit, unit);
    write_reg(frsm_pkg::CfgStripeCount, width);
    write_reg(frsm_pkg::CfgObjectSize, osize);
    layout_unit = unit;
  endtask

  initial begin
    logic [31:0] unit, width, osize, length;
    logic [62:0] offset;
    logic [63:0] span, eff_unit;
    sb             = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    file_id_i      = '0;
    revision_i     = '0;
    start_offset_i = '0;
    range_length_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = frsm_pkg::CfgStripeUnit;
    cfg_data_i     = '0;
    layout_unit    = frsm_pkg::StripeUnitRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset layout: zero length, boundary crossing, top offset, exact and excess chunk counts.
    send_range(64'd0, 64'd0, 63'd0, 32'd0);
    send_range('1, '1, 63'd0, 32'd1);
    send_range(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 63'd4194303, 32'd2);
    send_range(64'd7, 64'd9, OffsetMax, 32'd1);
    send_range(64'd1, 64'd2, OffsetMax - 63'd10, 32'hFFFF_FFFF);
    send_range(64'd3, 64'd4, 63'd0, 32'h1000_0000);
    send_range(64'd5, 64'd6, 63'd0, 32'h1000_0001);
    send_range(64'd8, 64'd10, 63'd123, 32'hFFFF_FFFF);

    // Upper data bits of the stripe count write are dropped.
    apply_layout(32'd16, 32'h0003_0003, 32'd64);
    send_range(64'd11, 64'd12, 63'd0, 32'd384);
    send_range(64'd13, 64'd14, 63'd5, 32'd100);
    send_range(64'd15, 64'd16, OffsetMax - 63'd50, 32'd100);
    send_range(64'd17, 64'd18, 63'd17, 32'd0);

    // Zero unit, count and object size all fall back to one.
    apply_layout(32'd0, 32'd0, 32'd0);
    send_range(64'd19, 64'd20, 63'd10, 32'd5);
    send_range(64'd21, 64'd22, 63'd0, 32'd70);

    // Object smaller than one stripe unit.
    apply_layout(32'd100, 32'd2, 32'd50);
    send_range(64'd23, 64'd24, 63'd0, 32'd450);
    send_range(64'd25, 64'd26, 63'd99, 32'd2);

    apply_layout(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_range(64'd27, 64'd28, 63'd0, 32'hFFFF_FFFF);
    send_range(64'd29, 64'd30, OffsetMax, 32'hFFFF_FFFF);
    send_range(64'd31, 64'd32, 63'hFFFF_FFFE, 32'd3);

    apply_layout(32'd1, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_range(64'd33, 64'd34, OffsetMax - 63'd63, 32'd64);
    send_range(64'd35, 64'd36, 63'd0, 32'd63);

    for (int p = 0; p < RandPhases; p++) begin
      case ($urandom_range(0, 9))
        0:       unit = 32'd0;
        1:       unit = 32'd1;
        2, 3, 4, 5: unit = $urandom_range(2, 64);
        6, 7:    unit = $urandom_range(65, 65536);
        8:       unit = $urandom;
        default: unit = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 7))
        0:       width = 32'd0;
        1:       width = 32'd1;
        2, 3, 4: width = $urandom_range(2, 8);
        5, 6:    width = $urandom_range(9, 65535);
        default: width = 32'h0000_FFFF;
      endcase
      case ($urandom_range(0, 5))
        0:       osize = 32'd0;
        1:       osize = unit >> 1;
        2, 3, 4: osize = unit * $urandom_range(1, 8);
        default: osize = $urandom;
      endcase
      apply_layout(unit, width, osize);
      gaps_on  = (p % 3 != 1);
      eff_unit = (layout_unit == 0) ? 64'd1 : 64'(layout_unit);
      for (int i = 0; i < PhaseItems; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: offset = 63'($urandom_range(0, 32'h0010_0000));
          6, 7, 8:          offset = 63'({$urandom, $urandom});
          default:          offset = OffsetMax - 63'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 9))
          0:       length = 32'd0;
          1:       length = $urandom;
          2:       length = 32'hFFFF_FFFF;
          3:       length = $urandom_range(1, 4);
          default: begin
            span   = eff_unit * $urandom_range(0, 8) + 64'($urandom_range(0, eff_unit[31:0]));
            length = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
          end
        endcase
        send_range({$urandom, $urandom}, {$urandom, $urandom}, offset, length);
        if (p == 3 && i == PhaseItems / 2) drain();
      end
    end

    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (EndCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
